// File: hw/rtl/vrsc_pkg.sv
// Shared types, register codes and schedule constants for the velocity ramp block.
`default_nettype none

package vrsc_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned VEL_W = 20;
  localparam int unsigned STEP_W = 19;
  localparam int unsigned WIN_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned LEVEL_W = 3;

  // Schedule table: start time in ms and level velocity in Q12.8 mm/s.
  localparam int unsigned ROM_LEVELS = 4;
  localparam int unsigned SCHED_LEVELS = 4;
  localparam int unsigned ACTIVE_LEVELS =
      (SCHED_LEVELS < ROM_LEVELS) ? SCHED_LEVELS : ROM_LEVELS;

  localparam logic [TIME_W-1:0] SCHED_START [ROM_LEVELS] = '{
    32'd0, 32'd300, 32'd600, 32'd900
  };
  localparam logic signed [VEL_W-1:0] SCHED_VEL [ROM_LEVELS] = '{
    20'sd12800, 20'sd38400, 20'sd7680, 20'sd0
  };

  // Level code held after reset, before any level has been seen.
  localparam logic [LEVEL_W-1:0] LEVEL_NONE = 3'd7;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = 19'd512;
  localparam logic [WIN_W-1:0] ACCEL_WIN_RST = 16'd100;
  localparam logic [WIN_W-1:0] BRAKE_WIN_RST = 16'd100;

  typedef enum logic [1:0] {
    REG_MAX_STEP  = 2'd0,
    REG_ACCEL_WIN = 2'd1,
    REG_BRAKE_WIN = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0] max_step;
    logic [WIN_W-1:0]  accel_window;
    logic [WIN_W-1:0]  brake_window;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/vrsc_if.sv
// Handshake channel interfaces for input ticks and result beats.
`default_nettype none

interface vrsc_tick_if;
  logic                    valid;
  logic                    ready;
  logic [31:0]             time_ms;
  logic                    target_present;
  logic signed [19:0]      target_velocity;

  modport source (output valid, time_ms, target_present, target_velocity, input ready);
  modport sink (input valid, time_ms, target_present, target_velocity, output ready);
endinterface

interface vrsc_result_if;
  logic                    valid;
  logic                    ready;
  logic signed [19:0]      actual_velocity;
  logic                    settled_ok;
  logic                    accel_window_on;
  logic                    brake_window_on;

  modport source (output valid, actual_velocity, settled_ok, accel_window_on,
                  brake_window_on, input ready);
  modport sink (input valid, actual_velocity, settled_ok, accel_window_on,
                brake_window_on, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/vrsc_regs.sv
// APB-style configuration registers: max step and the two settle windows.
`default_nettype none

module vrsc_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [vrsc_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [vrsc_pkg::DATA_W-1:0]    pwdata,
  output logic      [vrsc_pkg::DATA_W-1:0]    prdata,
  output logic                                pready,
  output vrsc_pkg::cfg_t                      cfg
);

  vrsc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = vrsc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_step     <= vrsc_pkg::MAX_STEP_RST;
      cfg.accel_window <= vrsc_pkg::ACCEL_WIN_RST;
      cfg.brake_window <= vrsc_pkg::BRAKE_WIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        vrsc_pkg::REG_MAX_STEP:  cfg.max_step     <= pwdata[vrsc_pkg::STEP_W-1:0];
        vrsc_pkg::REG_ACCEL_WIN: cfg.accel_window <= pwdata[vrsc_pkg::WIN_W-1:0];
        vrsc_pkg::REG_BRAKE_WIN: cfg.brake_window <= pwdata[vrsc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      vrsc_pkg::REG_MAX_STEP:
        prdata = {{(vrsc_pkg::DATA_W-vrsc_pkg::STEP_W){1'b0}}, cfg.max_step};
      vrsc_pkg::REG_ACCEL_WIN:
        prdata = {{(vrsc_pkg::DATA_W-vrsc_pkg::WIN_W){1'b0}}, cfg.accel_window};
      vrsc_pkg::REG_BRAKE_WIN:
        prdata = {{(vrsc_pkg::DATA_W-vrsc_pkg::WIN_W){1'b0}}, cfg.brake_window};
      default:
        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/vrsc_slew.sv
// Slew limiter: moves the current velocity toward the target by at most one step.
`default_nettype none

module vrsc_slew (
  input  wire logic signed [vrsc_pkg::VEL_W-1:0]  cur,
  input  wire logic signed [vrsc_pkg::VEL_W-1:0]  tgt,
  input  wire logic        [vrsc_pkg::STEP_W-1:0] step,
  output logic signed      [vrsc_pkg::VEL_W-1:0]  nxt
);

  logic signed [vrsc_pkg::VEL_W:0] diff;
  logic signed [vrsc_pkg::VEL_W:0] step_s;
  logic signed [vrsc_pkg::VEL_W:0] up;
  logic signed [vrsc_pkg::VEL_W:0] down;

  assign diff   = {tgt[vrsc_pkg::VEL_W-1], tgt} - {cur[vrsc_pkg::VEL_W-1], cur};
  assign step_s = $signed({2'b00, step});
  assign up     = {cur[vrsc_pkg::VEL_W-1], cur} + step_s;
  assign down   = {cur[vrsc_pkg::VEL_W-1], cur} - step_s;

  // A full step is taken only when the target lies beyond it, so the
  // truncated sum always fits the velocity width.
  always_comb begin
    priority if (diff > step_s) begin
      nxt = up[vrsc_pkg::VEL_W-1:0];
    end else if (diff < -step_s) begin
      nxt = down[vrsc_pkg::VEL_W-1:0];
    end else begin
      nxt = tgt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/vrsc_datapath.sv
// Input register, velocity and level state, window check and result register.
`default_nettype none

module vrsc_datapath (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire vrsc_pkg::cfg_t cfg,
  vrsc_tick_if.sink         tick,
  vrsc_result_if.source     result
);

  // Input register.
  logic                                 s1_valid;
  logic [vrsc_pkg::TIME_W-1:0]          s1_time;
  logic                                 s1_present;
  logic signed [vrsc_pkg::VEL_W-1:0]    s1_target;

  // Feedback state.
  logic signed [vrsc_pkg::VEL_W-1:0]    velocity;
  logic                                 accelerating;
  logic [vrsc_pkg::LEVEL_W-1:0]         latched_level;

  logic                                 advance;
  logic                                 take;
  logic [vrsc_pkg::LEVEL_W-1:0]         level;
  logic signed [vrsc_pkg::VEL_W-1:0]    desired;
  logic signed [vrsc_pkg::VEL_W-1:0]    velocity_next;
  logic                                 accelerating_next;
  logic [vrsc_pkg::TIME_W-1:0]          since;
  logic [vrsc_pkg::WIN_W-1:0]           win;
  logic                                 passed;

  assign advance    = !result.valid || result.ready;
  assign take       = s1_valid && advance;
  assign tick.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.valid && tick.ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_time    <= tick.time_ms;
      s1_present <= tick.target_present;
      s1_target  <= tick.target_velocity;
    end
  end

  // Schedule level: the last entry whose start time has been reached.
  always_comb begin
    level = '0;
    for (int i = 0; i < vrsc_pkg::ACTIVE_LEVELS; i++) begin
      if (s1_time >= vrsc_pkg::SCHED_START[i]) begin
        level = vrsc_pkg::LEVEL_W'(i);
      end
    end
  end

  assign desired = s1_present ? s1_target : vrsc_pkg::SCHED_VEL[level[1:0]];

  vrsc_slew u_slew (
    .cur  (velocity),
    .tgt  (desired),
    .step (cfg.max_step),
    .nxt  (velocity_next)
  );

  // Direction is decided against the velocity from before this tick.
  assign accelerating_next = (level != latched_level) ? (desired >= velocity) : accelerating;

  assign since  = s1_time - vrsc_pkg::SCHED_START[level[1:0]];
  assign win    = accelerating_next ? cfg.accel_window : cfg.brake_window;
  assign passed = since >= {{(vrsc_pkg::TIME_W-vrsc_pkg::WIN_W){1'b0}}, win};

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity      <= '0;
      accelerating  <= 1'b1;
      latched_level <= vrsc_pkg::LEVEL_NONE;
    end else if (take) begin
      velocity      <= velocity_next;
      accelerating  <= accelerating_next;
      latched_level <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.actual_velocity <= velocity_next;
      result.settled_ok      <= !passed || (velocity_next == desired);
      result.accel_window_on <= accelerating_next &&
          (since < {{(vrsc_pkg::TIME_W-vrsc_pkg::WIN_W){1'b0}}, cfg.accel_window});
      result.brake_window_on <= !accelerating_next &&
          (since < {{(vrsc_pkg::TIME_W-vrsc_pkg::WIN_W){1'b0}}, cfg.brake_window});
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/velocity_ramp_settle_check.sv
// Top level of the slew-limited velocity ramp with settle-in-time check.
// Each tick beat is one millisecond. The block accepts one tick per clock cycle while
// the result side is not stalled, and each accepted tick passes through the input
// register, then through the slew and window logic into the result
// register. The stored velocity feeds back through a single register, so a tick
// sees the velocity left by the one before it with no gap. A stalled result beat
// still lets one more tick into the input register. Configuration registers
// (APB, byte addresses 0x0 max_step, 0x4 accel_window, 0x8 brake_window) should
// be written only while no tick is in flight.
`default_nettype none

module velocity_ramp_settle_check (
  input  wire logic                         clk,
  input  wire logic                         rst,
  vrsc_tick_if.sink                         tick,
  vrsc_result_if.source                     result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [vrsc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [vrsc_pkg::DATA_W-1:0]  pwdata,
  output logic      [vrsc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  vrsc_pkg::cfg_t cfg;

  vrsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vrsc_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .tick   (tick),
    .result (result)
  );

endmodule

`default_nettype wire

// File: hw/rtl/vrsc_checker.sv
// Port-level checks on the velocity ramp block, bound to its top level.
`default_nettype none

module vrsc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              tick_ready,
  input wire logic              res_valid,
  input wire logic              res_ready,
  input wire logic signed [19:0] res_velocity,
  input wire logic              res_ok,
  input wire logic              res_acc_on,
  input wire logic              res_brk_on
);

  // A stalled result beat keeps its payload.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_velocity) && $stable(res_ok))
    else $error("result beat changed while stalled");

  // Open windows mean the deadline has not passed.
  a_window_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_acc_on || res_brk_on) |-> res_ok)
    else $error("settled_ok low inside an open window");

  a_one_window: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_acc_on && res_brk_on))
    else $error("both windows on at once");

  // A free output side never blocks the tick side.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> tick_ready)
    else $error("tick stalled while result side is ready");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result beat right after reset");

endmodule

bind velocity_ramp_settle_check vrsc_checker u_vrsc_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_ready   (tick.ready),
  .res_valid    (result.valid),
  .res_ready    (result.ready),
  .res_velocity (result.actual_velocity),
  .res_ok       (result.settled_ok),
  .res_acc_on   (result.accel_window_on),
  .res_brk_on   (result.brake_window_on)
);

`default_nettype wire

// File: sim/velocity_ramp_settle_check_checker.sv
// Checker that predicts every result beat of the velocity ramp and compares it field by field.
module velocity_ramp_settle_check_checker
  import vrsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  vrsc_tick_if              tick,
  vrsc_result_if            result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending,
  output int                beats_checked,
  output int                late_settles,
  output int                brake_beats
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic                    settled_ok;
    logic                    accel_on;
    logic                    brake_on;
  } ramp_beat_t;

  ramp_beat_t expected_ramp [$];

  logic signed [VEL_W-1:0] ramp_vel;
  logic                    ramp_accel;
  logic [LEVEL_W-1:0]      ramp_level;
  cfg_t                    ramp_cfg;

  int fails = 0;
  int checked = 0;
  int late = 0;
  int brakes = 0;

  function automatic logic signed [VEL_W-1:0] slew_toward(
    input logic signed [VEL_W-1:0] cur,
    input logic signed [VEL_W-1:0] tgt,
    input logic [STEP_W-1:0]       step
  );
    int diff;
    int lim;
    diff = int'(tgt) - int'(cur);
    lim = int'(step);
    if (diff > lim) return VEL_W'(int'(cur) + lim);
    if (diff < -lim) return VEL_W'(int'(cur) - lim);
    return tgt;
  endfunction

  // Advances the ramp state by one tick and returns the beat it should produce.
  task automatic advance_ramp(
    input  logic [TIME_W-1:0]       t,
    input  logic                    present,
    input  logic signed [VEL_W-1:0] tv,
    output ramp_beat_t              beat
  );
    logic [LEVEL_W-1:0]      level;
    logic signed [VEL_W-1:0] desired;
    logic signed [VEL_W-1:0] prev;
    logic [TIME_W-1:0]       since;
    logic [WIN_W-1:0]        win;
    logic                    passed;
    level = '0;
    for (int i = 0; i < ACTIVE_LEVELS; i++)
      if (t >= SCHED_START[i]) level = LEVEL_W'(i);
    desired = present ? tv : SCHED_VEL[level[1:0]];
    prev = ramp_vel;
    ramp_vel = slew_toward(ramp_vel, desired, ramp_cfg.max_step);
    // The direction is decided against the velocity held before this tick.
    if (level != ramp_level) begin
      ramp_accel = (desired >= prev);
      ramp_level = level;
    end
    since = t - SCHED_START[level[1:0]];
    win = ramp_accel ? ramp_cfg.accel_window : ramp_cfg.brake_window;
    passed = (since >= win);
    beat.velocity = ramp_vel;
    beat.settled_ok = !passed || (ramp_vel == desired);
    beat.accel_on = ramp_accel && (since < ramp_cfg.accel_window);
    beat.brake_on = !ramp_accel && (since < ramp_cfg.brake_window);
  endtask

  always @(posedge clk) begin
    ramp_beat_t want;
    ramp_beat_t got;
    if (rst) begin
      ramp_vel = '0;
      ramp_accel = 1'b1;
      ramp_level = LEVEL_NONE;
      ramp_cfg.max_step = MAX_STEP_RST;
      ramp_cfg.accel_window = ACCEL_WIN_RST;
      ramp_cfg.brake_window = BRAKE_WIN_RST;
      expected_ramp.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MAX_STEP:  ramp_cfg.max_step = pwdata[STEP_W-1:0];
          REG_ACCEL_WIN: ramp_cfg.accel_window = pwdata[WIN_W-1:0];
          REG_BRAKE_WIN: ramp_cfg.brake_window = pwdata[WIN_W-1:0];
          default: ;
        endcase
      end
      // A result beat at this edge always belongs to an earlier tick, so pop before push.
      if (result.valid && result.ready) begin
        got.velocity = result.actual_velocity;
        got.settled_ok = result.settled_ok;
        got.accel_on = result.accel_window_on;
        got.brake_on = result.brake_window_on;
        if (expected_ramp.size() == 0) begin
          $error("result beat with no tick waiting: actual_velocity %0d", got.velocity);
          fails++;
        end else begin
          want = expected_ramp.pop_front();
          if (got.velocity !== want.velocity) begin
            $error("actual_velocity: expected %0d, got %0d", want.velocity, got.velocity);
            fails++;
          end
          if (got.settled_ok !== want.settled_ok) begin
            $error("settled_ok: expected %0d, got %0d", want.settled_ok, got.settled_ok);
            fails++;
          end
          if (got.accel_on !== want.accel_on) begin
            $error("accel_window_on: expected %0d, got %0d", want.accel_on, got.accel_on);
            fails++;
          end
          if (got.brake_on !== want.brake_on) begin
            $error("brake_window_on: expected %0d, got %0d", want.brake_on, got.brake_on);
            fails++;
          end
          checked++;
          if (!want.settled_ok) late++;
          if (want.brake_on) brakes++;
        end
      end
      if (tick.valid && tick.ready) begin
        advance_ramp(tick.time_ms, tick.target_present, tick.target_velocity, want);
        expected_ramp.push_back(want);
      end
    end
    fail_count <= fails;
    pending <= expected_ramp.size();
    beats_checked <= checked;
    late_settles <= late;
    brake_beats <= brakes;
  end

endmodule

// File: sim/velocity_ramp_settle_check_test.sv
// Testbench top: drives ticks, result stalls and register writes, then gives the verdict.
module velocity_ramp_settle_check_test;
  timeunit 1ns;
  timeprecision 1ps;
  import vrsc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int beats_checked;
  int late_settles;
  int brake_beats;
  int ticks_sent = 0;
  int reg_writes = 0;
  int settings = 1;
  int cycles = 0;
  bit tick_calm = 1'b0;

  vrsc_tick_if   tick_ch ();
  vrsc_result_if result_ch ();

  velocity_ramp_settle_check u_top (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  velocity_ramp_settle_check_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick_ch),
    .result        (result_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked),
    .late_settles  (late_settles),
    .brake_beats   (brake_beats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WIN_W'(1);
      3: return ACCEL_WIN_RST;
      default: return WIN_W'($urandom_range(1, 400));
    endcase
  endfunction

  // Result side: random stalls, with an occasional long stretch of steady ready.
  initial begin
    int stall;
    int run;
    result_ch.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        stall = 0;
        run = $urandom_range(30, 120);
      end else begin
        stall = pick_gap(1'b0);
        run = $urandom_range(1, 12);
      end
      repeat (stall) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
      end
      repeat (run) begin
        @(negedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Presents one tick after a random gap and returns at the edge that accepts it.
  task automatic send_tick(
    input logic [TIME_W-1:0]       t,
    input logic                    present,
    input logic signed [VEL_W-1:0] tv
  );
    int gap;
    gap = pick_gap(tick_calm);
    repeat (gap) begin
      @(negedge clk);
      tick_ch.valid <= 1'b0;
    end
    @(negedge clk);
    tick_ch.valid <= 1'b1;
    tick_ch.time_ms <= t;
    tick_ch.target_present <= present;
    tick_ch.target_velocity <= tv;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    tick_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg_addr(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    reg_writes++;
  endtask

  task automatic set_config(
    input logic [STEP_W-1:0] step,
    input logic [WIN_W-1:0]  accw,
    input logic [WIN_W-1:0]  brkw
  );
    drain_results();
    // Let the two-stage pipeline go quiet before touching the registers.
    repeat (4) @(negedge clk);
    write_reg_addr({REG_MAX_STEP, 2'b00}, DATA_W'(step));
    write_reg_addr({REG_ACCEL_WIN, 2'b00}, DATA_W'(accw));
    write_reg_addr({REG_BRAKE_WIN, 2'b00}, DATA_W'(brkw));
    settings++;
  endtask

  initial begin
    logic [TIME_W-1:0]       t;
    logic                    present;
    logic signed [VEL_W-1:0] tv;
    logic [STEP_W-1:0]       step;
    int                      len;
    int                      pct;
    int                      pick;
    int                      lvl;
    int                      phase_end;
    bit                      broken;
    bit                      paused;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.time_ms = '0;
    tick_ch.target_present = 1'b0;
    tick_ch.target_velocity = '0;
    paused = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: level boundaries, both velocity extremes, the end of the time range.
    send_tick(32'd0, 1'b0, '0);
    send_tick(32'd1, 1'b0, '0);
    send_tick(32'd299, 1'b0, '0);
    send_tick(32'd300, 1'b0, '0);
    send_tick(32'd301, 1'b1, 20'sh7FFFF);
    send_tick(32'd302, 1'b1, 20'sh80000);
    send_tick(32'd600, 1'b0, '0);
    send_tick(32'd900, 1'b0, '0);
    send_tick(32'hFFFF_FFFF, 1'b0, '0);
    send_tick(32'd0, 1'b0, '0);
    send_tick(32'd99, 1'b1, 20'sd12800);
    send_tick(32'd100, 1'b0, '0);

    // Full-scale step with zero windows: full swings, and every window flag drops at once.
    set_config('1, '0, '0);
    send_tick(32'd0, 1'b1, 20'sh80000);
    send_tick(32'd1, 1'b1, 20'sh7FFFF);
    send_tick(32'd2, 1'b1, 20'sh80000);
    send_tick(32'd300, 1'b0, '0);
    send_tick(32'd301, 1'b1, '0);
    send_tick(32'd302, 1'b1, '0);

    // Zero step holds the velocity, now known to be zero; the write to the
    // unmapped address must leave every register alone.
    set_config('0, '1, '1);
    write_reg_addr(ADDR_W'(12), 32'hFFFF_FFFF);
    send_tick(32'd303, 1'b1, '0);
    send_tick(32'd304, 1'b1, 20'sd5);
    send_tick(32'd600, 1'b0, '0);
    send_tick(32'd900, 1'b0, '0);

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 9))
        0: step = '0;
        1: step = '1;
        2: step = STEP_W'(1);
        3, 4: step = MAX_STEP_RST;
        default: step = STEP_W'($urandom_range(1, 4096));
      endcase
      set_config(step, pick_window(), pick_window());
      phase_end = ticks_sent + 190;
      while (ticks_sent < phase_end) begin
        tick_calm = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          // A run of consecutive milliseconds around one schedule level, with occasional jumps in broken runs.
          lvl = $urandom_range(0, ROM_LEVELS - 1);
          if (lvl == 0) t = TIME_W'($urandom_range(0, 100));
          else t = SCHED_START[lvl] - TIME_W'($urandom_range(0, 120));
          len = $urandom_range(10, 160);
          case ($urandom_range(0, 3))
            0, 1: pct = 0;
            2: pct = 10;
            default: pct = 50;
          endcase
          broken = (pick < 12);
          for (int k = 0; k < len; k++) begin
            present = ($urandom_range(0, 99) < pct);
            if ($urandom_range(0, 1) == 0) tv = VEL_W'($urandom);
            else tv = VEL_W'(int'(SCHED_VEL[lvl]) + int'($urandom_range(0, 4000)) - 2000);
            send_tick(t, present, tv);
            if (broken && $urandom_range(0, 9) == 0) t = t + $urandom_range(0, 600) - 300;
            else t = t + 1;
          end
        end else begin
          repeat ($urandom_range(1, 8)) send_tick($urandom, 1'($urandom), VEL_W'($urandom));
        end
        if (ph == 2 && !paused && ticks_sent > phase_end - 140) begin
          drain_results();
          paused = 1'b1;
        end
      end
    end

    drain_results();
    repeat (10) @(negedge clk);
    $display("Run covered %0d ticks under %0d register settings (%0d writes), from zero to",
             ticks_sent, settings, reg_writes);
    $display("full-scale steps and windows; %0d beats checked, %0d late settles, %0d braking.",
             beats_checked, late_settles, brake_beats);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
